[src/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Line size, command codes, terminal byte codes and the decimal digit helpers.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_WIDTH  = 40;
  localparam int LEN_W       = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W      = $clog2(LINE_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int SEQ_BYTES   = 8;
  localparam int SEQ_CNT_W   = $clog2(SEQ_BYTES + 1);

  // Terminal byte codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ERASE  = 2'd0,
    REG_KILL   = 2'd1,
    REG_WERASE = 2'd2,
    REG_EOF    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] word_erase_char;
    logic [7:0] eof_char;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_ERASE,
    CMD_KILL,
    CMD_WERASE,
    CMD_EOF,
    CMD_BELL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FORM,
    B_EMIT
  } back_state_t;

  // Tens digit of a count below 100.
  function automatic logic [3:0] tens_of(input logic [LEN_W-1:0] n);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (int'(n) >= 10 * k) t = 4'(k);
    end
    return t;
  endfunction

  // Ones digit of a count below 100.
  function automatic logic [3:0] ones_of(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n - LEN_W'(int'(tens_of(n)) * 10);
    return r[3:0];
  endfunction

endpackage

[src/tle_front.sv]
// ----------------------------------------------------------------------------
// tle_front: input stage of the terminal line editor
// Accepts typed bytes, classifies them against the control codes, and holds
// the classified item until the command queue takes it.
// ----------------------------------------------------------------------------
module tle_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  tle_pkg::cfg_t cfg,
  output logic          push_valid,
  output tle_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import tle_pkg::*;

  logic      hold_valid;
  cmd_t      hold_cmd;
  cmd_t      cmd_next;
  logic      accept;

  // Printable bytes always append; control codes match in register order.
  always_comb begin
    cmd_next.data = in_byte;
    priority if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
      cmd_next.kind = CMD_PRINT;
    end else if (in_byte == cfg.erase_char) begin
      cmd_next.kind = CMD_ERASE;
    end else if (in_byte == cfg.kill_char) begin
      cmd_next.kind = CMD_KILL;
    end else if (in_byte == cfg.word_erase_char) begin
      cmd_next.kind = CMD_WERASE;
    end else if (in_byte == cfg.eof_char) begin
      cmd_next.kind = CMD_EOF;
    end else begin
      cmd_next.kind = CMD_BELL;
    end
  end

  assign in_ready   = !hold_valid || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= cmd_next;
    end
  end

endmodule

[src/tle_queue.sv]
// ----------------------------------------------------------------------------
// tle_queue: command queue of the terminal line editor
// Short FIFO between the classifier and the line engine.
// ----------------------------------------------------------------------------
module tle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tle_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tle_pkg::cmd_t pop_cmd
);
  import tle_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[src/tle_back.sv]
// ----------------------------------------------------------------------------
// tle_back: line engine of the terminal line editor
// Owns the line store, carries out each command, scans for the last word
// start and streams the echo bytes through a one-entry output register.
// ----------------------------------------------------------------------------
module tle_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tle_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          has_byte,
  output logic          last,
  output logic          session_end
);
  import tle_pkg::*;

  localparam int SEQ_W = SEQ_BYTES * 8;

  back_state_t      state;
  back_state_t      state_next;
  logic [LEN_W-1:0] line_len;
  logic             ended;

  logic [7:0]       line_store [LINE_WIDTH];
  logic [7:0]       rd_data;
  logic [ADDR_W-1:0] rd_idx;
  logic             rd_pend;
  logic [LEN_W-1:0] scan_idx;
  logic [7:0]       prev_ch;
  logic [LEN_W-1:0] start;
  logic [LEN_W-1:0] wn;

  logic [SEQ_W-1:0]     seq;
  logic [SEQ_CNT_W-1:0] seq_cnt;
  logic                 seq_end;

  logic pop_fire;
  logic scan_issue;
  logic scan_done;
  logic slot_free;
  logic emit_fire;
  logic line_full;
  logic store_we;
  logic [ADDR_W-1:0] store_waddr;
  logic [3:0] tens_d;
  logic [3:0] ones_d;

  assign line_full = (line_len >= LEN_W'(LINE_WIDTH));
  assign slot_free = !out_valid || out_ready;
  assign tens_d    = tens_of(wn);
  assign ones_d    = ones_of(wn);

  // Control outputs of the sequencer
  always_comb begin
    pop_ready   = (state == B_IDLE);
    pop_fire    = pop_valid && (state == B_IDLE);
    scan_issue  = (state == B_SCAN) && (scan_idx < line_len);
    scan_done   = (state == B_SCAN) && (scan_idx == line_len) && !rd_pend;
    emit_fire   = (state == B_EMIT) && slot_free;
    store_we    = pop_fire && !ended && (pop_cmd.kind == CMD_PRINT);
    store_waddr = line_full ? '0 : line_len[ADDR_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop_valid && !ended) begin
          if (pop_cmd.kind == CMD_WERASE && line_len != '0) begin
            state_next = B_SCAN;
          end else begin
            state_next = B_EMIT;
          end
        end
      end
      B_SCAN: begin
        if (scan_done) state_next = B_FORM;
      end
      B_FORM: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free && seq_cnt <= SEQ_CNT_W'(1)) state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[store_waddr] <= pop_cmd.data;
    end
    rd_data <= line_store[scan_idx[ADDR_W-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      line_len  <= '0;
      ended     <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      seq_cnt   <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= scan_issue;

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop_fire && !ended) begin
        unique case (pop_cmd.kind)
          CMD_PRINT: begin
            line_len <= line_full ? LEN_W'(1) : line_len + 1'b1;
            seq_cnt  <= line_full ? SEQ_CNT_W'(2) : SEQ_CNT_W'(1);
          end
          CMD_ERASE: begin
            if (line_len != '0) begin
              line_len <= line_len - 1'b1;
              seq_cnt  <= SEQ_CNT_W'(6);
            end else begin
              seq_cnt  <= '0;
            end
          end
          CMD_KILL: begin
            line_len <= '0;
            seq_cnt  <= SEQ_CNT_W'(5);
          end
          CMD_WERASE: begin
            seq_cnt <= '0;
          end
          CMD_EOF: begin
            if (line_len == '0) ended <= 1'b1;
            seq_cnt <= '0;
          end
          CMD_BELL: begin
            seq_cnt <= SEQ_CNT_W'(1);
          end
          default: begin
            seq_cnt <= '0;
          end
        endcase
      end else if (scan_done) begin
        line_len <= start;
      end else if (state == B_FORM) begin
        seq_cnt <= (tens_d != 4'd0) ? SEQ_CNT_W'(8) : SEQ_CNT_W'(7);
      end else if (emit_fire && seq_cnt != '0) begin
        seq_cnt <= seq_cnt - 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop_fire && !ended) begin
      seq_end  <= (pop_cmd.kind == CMD_EOF) && (line_len == '0);
      prev_ch  <= CH_SPACE;
      start    <= '0;
      scan_idx <= '0;
      unique case (pop_cmd.kind)
        CMD_PRINT: begin
          seq <= line_full ? SEQ_W'({pop_cmd.data, CH_LF}) : SEQ_W'(pop_cmd.data);
        end
        CMD_ERASE: begin
          seq <= SEQ_W'({CH_UP_K, CH_LBRK, CH_ESC, CH_UP_D, CH_LBRK, CH_ESC});
        end
        CMD_KILL: begin
          seq <= SEQ_W'({CH_CR, CH_UP_K, CH_TWO, CH_LBRK, CH_ESC});
        end
        CMD_BELL: begin
          seq <= SEQ_W'(CH_BEL);
        end
        default: begin
          seq <= '0;
        end
      endcase
    end else begin
      if (scan_issue) scan_idx <= scan_idx + 1'b1;
      rd_idx <= scan_idx[ADDR_W-1:0];
      // A word starts at a non-space right after a space or the line start
      if (rd_pend) begin
        if (rd_data != CH_SPACE && prev_ch == CH_SPACE) begin
          start <= LEN_W'(rd_idx);
        end
        prev_ch <= rd_data;
      end
      if (scan_done) wn <= line_len - start;
      if (state == B_FORM) begin
        if (tens_d != 4'd0) begin
          seq <= SEQ_W'({CH_UP_K, CH_LBRK, CH_ESC, CH_UP_D,
                         CH_ZERO | {4'h0, ones_d}, CH_ZERO | {4'h0, tens_d},
                         CH_LBRK, CH_ESC});
        end else begin
          seq <= SEQ_W'({CH_UP_K, CH_LBRK, CH_ESC, CH_UP_D,
                         CH_ZERO | {4'h0, ones_d}, CH_LBRK, CH_ESC});
        end
      end else if (emit_fire) begin
        seq <= seq >> 8;
      end
    end

    // Load the output register; an empty sequence yields one empty result
    if (emit_fire) begin
      out_byte    <= (seq_cnt != '0) ? seq[7:0] : 8'h00;
      has_byte    <= (seq_cnt != '0);
      last        <= (seq_cnt <= SEQ_CNT_W'(1));
      session_end <= (seq_cnt == '0) && seq_end;
    end
  end

endmodule

[src/terminal_line_editor.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor: keyboard line editor with terminal echo
// Top level: configuration registers, classifier, command queue, line engine.
// ----------------------------------------------------------------------------
// Usage:
//   Typed bytes enter on in_valid/in_ready/in_byte. Each item produces one
//   or more results on out_valid/out_ready with out_byte, has_byte, last and
//   session_end; last marks the final result of an item. After an EOF on an
//   empty line, every later item is taken and dropped with no result.
//   The classifier holds one item and the queue two more, so input keeps
//   flowing while the line engine works or the receiver stalls.
//   The line engine picks up an item and then sends its results, one to
//   eight, in order; it takes no new item until the last result of the
//   current one is loaded. Word erase first scans the line store through
//   its single read port, then forms the count.
//   A stalled receiver holds the output register and the engine waits.
//   Reset empties the line, clears the session end flag and loads the
//   default control codes; the line store needs no clearing.
//   Control codes are to be written over the APB port only while idle;
//   the user is bound by this and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module terminal_line_editor (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        has_byte,
  output logic        last,
  output logic        session_end
);
  import tle_pkg::*;

  cfg_t     cfg;
  cfg_reg_t reg_sel;
  logic     cfg_we;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Word addressing: register index sits above the byte offset
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char      <= 8'd127;
      cfg.kill_char       <= 8'd21;
      cfg.word_erase_char <= 8'd23;
      cfg.eof_char        <= 8'd4;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_ERASE:  cfg.erase_char      <= pwdata[7:0];
        REG_KILL:   cfg.kill_char       <= pwdata[7:0];
        REG_WERASE: cfg.word_erase_char <= pwdata[7:0];
        REG_EOF:    cfg.eof_char        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the selected control code
  always_comb begin
    unique case (reg_sel)
      REG_ERASE:  prdata = {24'h0, cfg.erase_char};
      REG_KILL:   prdata = {24'h0, cfg.kill_char};
      REG_WERASE: prdata = {24'h0, cfg.word_erase_char};
      REG_EOF:    prdata = {24'h0, cfg.eof_char};
      default:    prdata = 32'h0;
    endcase
  end

  // Classify incoming bytes
  tle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Decouple classification from line editing
  tle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Edit the line and stream the echo
  tle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .last        (last),
    .session_end (session_end)
  );

endmodule

[tb/tb_terminal_line_editor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_line_editor: self-checking bench for the terminal line editor
// Types keystrokes into the editor, keeps its own copy of the line buffer and
// control codes, and checks every echoed item against the predicted echo.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor;
  import tle_pkg::*;

  // Cycles without any handshake or register access before the run is called hung.
  // A word erase scans the line and a stalled receiver can hold a burst for
  // a while, but nothing legitimate comes near this.
  localparam int STALL_LIMIT = 4000;
  localparam int KEYS_PER_PHASE = 88;

  // One echoed item as the terminal should see it
  typedef struct {
    logic [7:0] ch;
    logic       has;
    logic       tail;
    logic       ended;
  } echo_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        last;
  logic        session_end;

  // Shadow of the editor: line buffer, length, session flag, control codes
  logic [7:0]  line_buf [LINE_WIDTH];
  int unsigned line_len;
  logic        sess_over;
  cfg_t        codes;

  echo_t       echo_q[$];
  int          mismatches;
  int          keys_typed;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  terminal_line_editor dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .last        (last),
    .session_end (session_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Echo prediction
  // ---------------------------------------------------------------------------

  // Classify a keystroke. Printable bytes never act as control codes; among
  // the codes, erase beats kill beats word erase beats end of file.
  function automatic cmd_kind_t key_kind(input logic [7:0] key);
    if (key >= CH_SPACE && key <= CH_TILDE) return CMD_PRINT;
    if (key == codes.erase_char)            return CMD_ERASE;
    if (key == codes.kill_char)             return CMD_KILL;
    if (key == codes.word_erase_char)       return CMD_WERASE;
    if (key == codes.eof_char)              return CMD_EOF;
    return CMD_BELL;
  endfunction

  // Apply one accepted keystroke to the shadow line and queue its echo.
  task automatic predict_echo(input logic [7:0] key);
    logic [7:0]  seq[$];
    int unsigned start;
    int unsigned n;
    logic [7:0]  prev;
    logic        eof_hit;
    echo_t       e;
    // Once the session is over every keystroke is swallowed silently
    if (sess_over) return;
    eof_hit = 1'b0;
    case (key_kind(key))
      CMD_PRINT: begin
        // Full line: move to a fresh line before placing the character
        if (line_len >= LINE_WIDTH) begin
          seq.push_back(CH_LF);
          line_len = 0;
        end
        line_buf[line_len] = key;
        line_len++;
        seq.push_back(key);
      end
      CMD_ERASE: begin
        if (line_len > 0) begin
          line_len--;
          seq = '{CH_ESC, CH_LBRK, CH_UP_D, CH_ESC, CH_LBRK, CH_UP_K};
        end
      end
      CMD_KILL: begin
        line_len = 0;
        seq = '{CH_ESC, CH_LBRK, CH_TWO, CH_UP_K, CH_CR};
      end
      CMD_WERASE: begin
        if (line_len > 0) begin
          // Last word start: a non-space after a space or at the line start;
          // a line of only spaces goes back to column zero
          start = 0;
          prev  = CH_SPACE;
          for (int i = 0; i < line_len; i++) begin
            if (line_buf[i] != CH_SPACE && prev == CH_SPACE) start = i;
            prev = line_buf[i];
          end
          n = line_len - start;
          line_len = start;
          seq = '{CH_ESC, CH_LBRK};
          if (n >= 10) seq.push_back(CH_ZERO + 8'(n / 10));
          seq.push_back(CH_ZERO + 8'(n % 10));
          seq.push_back(CH_UP_D);
          seq.push_back(CH_ESC);
          seq.push_back(CH_LBRK);
          seq.push_back(CH_UP_K);
        end
      end
      CMD_EOF: begin
        // End of file only counts on an empty line
        if (line_len == 0) begin
          sess_over = 1'b1;
          eof_hit   = 1'b1;
        end
      end
      default: seq.push_back(CH_BEL);
    endcase
    // Nothing to echo still yields one empty item marking the end
    if (seq.size() == 0) begin
      e.ch    = 8'h00;
      e.has   = 1'b0;
      e.tail  = 1'b1;
      e.ended = eof_hit;
      echo_q.push_back(e);
    end else begin
      foreach (seq[i]) begin
        e.ch    = seq[i];
        e.has   = 1'b1;
        e.tail  = (i == seq.size() - 1);
        e.ended = 1'b0;
        echo_q.push_back(e);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check each echoed item, then predict from each accepted key.
  // Both in one process so the queue always sees the check before the prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    echo_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (echo_q.size() == 0) begin
          $error("unexpected echo item: out_byte %02h has_byte %0b last %0b session_end %0b",
                 out_byte, has_byte, last, session_end);
          mismatches++;
        end else begin
          want = echo_q.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte mismatch: expected %02h, got %02h", want.ch, out_byte);
            mismatches++;
          end
          if (has_byte !== want.has) begin
            $error("has_byte mismatch: expected %0b, got %0b", want.has, has_byte);
            mismatches++;
          end
          if (last !== want.tail) begin
            $error("last mismatch: expected %0b, got %0b", want.tail, last);
            mismatches++;
          end
          if (session_end !== want.ended) begin
            $error("session_end mismatch: expected %0b, got %0b", want.ended, session_end);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_echo(in_byte);
    end
  end

  // Receiver: drop ready at random according to the current stall rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one keystroke, idling first at the current sender rate, and hold
  // it until taken. Valid stays high so the next key can follow at once.
  task automatic send_key(input logic [7:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= key;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random typing goes through here: never end the session by accident
  task automatic type_key(input logic [7:0] key);
    if (key_kind(key) == CMD_EOF && line_len == 0) return;
    send_key(key);
    keys_typed++;
  endtask

  // Stop typing and wait until every predicted item has been echoed
  task automatic go_quiet();
    in_valid <= 1'b0;
    while (echo_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input cfg_reg_t idx, input logic [7:0] wval,
                            output logic [31:0] rval);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, wval};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rval = prdata;
    if (wr) begin
      case (idx)
        REG_ERASE:  codes.erase_char      = wval;
        REG_KILL:   codes.kill_char       = wval;
        REG_WERASE: codes.word_erase_char = wval;
        REG_EOF:    codes.eof_char        = wval;
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_code(input cfg_reg_t idx, input logic [7:0] val);
    logic [31:0] rd;
    apb_access(1'b0, idx, 8'h00, rd);
    if (rd !== {24'd0, val}) begin
      $error("prdata mismatch for %s: expected %08h, got %08h", idx.name(), {24'd0, val}, rd);
      mismatches++;
    end
  endtask

  // Load all four control codes once the editor has gone idle, reading each back
  task automatic apply_codes(input logic [7:0] er, input logic [7:0] kl,
                             input logic [7:0] we, input logic [7:0] ef);
    logic [31:0] rd;
    go_quiet();
    apb_access(1'b1, REG_ERASE, er, rd);
    check_code(REG_ERASE, er);
    apb_access(1'b1, REG_KILL, kl, rd);
    check_code(REG_KILL, kl);
    apb_access(1'b1, REG_WERASE, we, rd);
    check_code(REG_WERASE, we);
    apb_access(1'b1, REG_EOF, ef, rd);
    check_code(REG_EOF, ef);
  endtask

  // Any non-printable byte, for random control codes
  function automatic logic [7:0] any_ctrl();
    int v;
    v = $urandom_range(0, 160);
    return (v < 32) ? 8'(v) : 8'(v + 95);
  endfunction

  function automatic logic [7:0] any_glyph();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // One random keystroke, weighted toward typing with edits sprinkled in
  function automatic logic [7:0] random_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return any_glyph();
    if (r < 62) return CH_SPACE;
    if (r < 70) return codes.erase_char;
    if (r < 74) return codes.kill_char;
    if (r < 82) return codes.word_erase_char;
    if (r < 85) return codes.eof_char;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_code(REG_ERASE, 8'd127);
    check_code(REG_KILL, 8'd21);
    check_code(REG_WERASE, 8'd23);
    check_code(REG_EOF, 8'd4);
  endtask

  // Echo, each edit command, edits on an empty line and bell bytes
  task automatic test_echo_and_edits();
    send_key(CH_SPACE);
    send_key("h");
    send_key("i");
    send_key(CH_SPACE);
    send_key(CH_TILDE);
    send_key("w");
    send_key(codes.erase_char);       // drop the w
    send_key(codes.word_erase_char);  // drop the tilde word
    send_key(codes.word_erase_char);  // drop "hi " back to the leading space
    send_key(codes.word_erase_char);  // a line of only spaces clears fully
    send_key(codes.word_erase_char);  // empty line: no byte echoed
    send_key(codes.erase_char);       // empty line: no byte echoed
    send_key(codes.kill_char);        // kill still echoes on an empty line
    send_key("q");
    send_key(codes.eof_char);         // end of file on a non-empty line is silent
    send_key(codes.kill_char);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h80);
    send_key(8'h1F);
  endtask

  // Codes that collide with printables or with each other
  task automatic test_shared_codes();
    apply_codes("A", "A", "A", "A");
    send_key("A");                    // printable wins over every code
    send_key("A");
    apply_codes(8'h01, 8'h01, 8'h01, 8'h01);
    send_key(8'h01);                  // erase has priority
    apply_codes(8'h02, 8'h05, 8'h05, 8'h05);
    send_key("k");
    send_key(8'h05);                  // kill beats word erase and end of file
    apply_codes(8'h02, 8'h03, 8'h06, 8'h06);
    send_key("z");
    send_key(CH_SPACE);
    send_key("y");
    send_key(8'h06);                  // word erase beats end of file
    send_key(8'h06);
  endtask

  // Random typing: well-formed words, long words, full lines and noise
  task automatic run_typing(input int n_keys);
    int goal;
    int pick;
    goal = keys_typed + n_keys;
    while (keys_typed < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Long word, then word erase; two-digit count unless the word wrapped
        if (line_len > 0) type_key(CH_SPACE);
        repeat ($urandom_range(10, 30)) type_key(any_glyph());
        type_key(codes.word_erase_char);
      end else if (pick < 14) begin
        // Fill the line and run past its end
        while (line_len < LINE_WIDTH) begin
          type_key(($urandom_range(0, 5) == 0) ? CH_SPACE : any_glyph());
        end
        repeat ($urandom_range(1, 3)) type_key(any_glyph());
      end else if (pick < 18) begin
        // Run of spaces, then word erase
        repeat ($urandom_range(1, 6)) type_key(CH_SPACE);
        type_key(codes.word_erase_char);
      end else if (pick < 20) begin
        go_quiet();
      end else begin
        type_key(random_key());
      end
    end
  endtask

  task automatic test_steady_typing();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_codes(8'd127, 8'd21, 8'd23, 8'd4);
    run_typing(KEYS_PER_PHASE);
  endtask

  task automatic test_slow_sender();
    apply_codes(8'h00, 8'hFF, 8'h80, 8'h1A);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_typing(KEYS_PER_PHASE);
  endtask

  task automatic test_slow_receiver();
    apply_codes(8'h08, 8'h15, 8'h7F, 8'hFF);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_typing(KEYS_PER_PHASE);
  endtask

  task automatic test_light_traffic();
    apply_codes(any_ctrl(), any_ctrl(), any_ctrl(), any_ctrl());
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    run_typing(KEYS_PER_PHASE);
  endtask

  // End of file on an empty line closes the session; later keys are dropped
  task automatic test_session_end();
    apply_codes(8'd127, 8'd21, 8'd23, 8'd4);
    send_key(codes.kill_char);
    send_key(codes.eof_char);
    repeat (6) send_key(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    out_ready      = 1'b0;
    line_len       = 0;
    sess_over      = 1'b0;
    codes.erase_char      = 8'd127;
    codes.kill_char       = 8'd21;
    codes.word_erase_char = 8'd23;
    codes.eof_char        = 8'd4;
    mismatches     = 0;
    keys_typed     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_defaults();
    test_echo_and_edits();
    test_shared_codes();
    test_steady_typing();
    test_slow_sender();
    test_slow_receiver();
    test_light_traffic();
    test_session_end();

    // Drain, then give the editor time to show anything stray
    go_quiet();
    repeat (30) @(negedge clk);
    if (echo_q.size() != 0) begin
      $error("%0d expected echo items never arrived", echo_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
